### rtl/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// Types, constants and the generator step for the shuffled lehmer generator
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int unsigned WORD_W       = 31;
    localparam int unsigned WARMUP_STEPS = 8;

    localparam logic [14:0]       LCG_MULT = 15'd16807;
    localparam logic [WORD_W-1:0] IM       = 31'h7FFF_FFFF;
    // cap constant 0.99999988 in q0.32
    localparam logic [31:0]       RNMX_Q32 = 32'd4294966781;
    localparam logic [63:0]       CAP_PROD = 64'd4294966781 * 64'd2147483647;
    localparam logic [WORD_W-1:0] CAP_WORD = CAP_PROD[62:32];

    typedef struct packed {
        logic [0:0]        operation;
        logic [WORD_W-1:0] range;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] scaled_value;
        logic [WORD_W-1:0] fraction_word;
    } t_out_item;

    localparam logic [0:0] OP_DRAW   = 1'b0;
    localparam logic [0:0] OP_RESEED = 1'b1;

    typedef struct packed {
        logic load_seed;
        logic capture_range;
        logic fill_step;
        logic draw_index;
        logic draw_fix;
        logic draw_swap;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic out_blocked;
    } t_status;

    // x * 16807 mod (2^31 - 1), folding the high part back in
    function automatic logic [WORD_W-1:0] lehmer_step(input logic [WORD_W-1:0] x);
        logic [45:0] prod;
        logic [31:0] fold;
        prod = {15'd0, x} * {31'd0, LCG_MULT};
        fold = {17'd0, prod[45:31]} + {1'b0, prod[30:0]};
        if (fold >= {1'b0, IM}) begin
            fold = fold - {1'b0, IM};
        end
        return fold[WORD_W-1:0];
    endfunction

endpackage

### rtl/shuffled_lehmer_random_generator_core.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core
// Lehmer generator mod 2^31-1 with a bays-durham shuffle table and scaling
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------
//  in       | input     | i_in_valid/o_in_stall   | t_in_item (operation, range)
//  out      | output    | o_out_valid/i_out_stall | t_out_item (scaled, fraction)
//  cfg      | input     | i_cfg_valid/o_cfg_ready | seed, 31 bits
//
//  a draw runs these steps before the next item is taken: accept, step and
//  index estimate, index fix and table read, table write and multiply, scale
//  a reseed runs accept, then 8 warm-up and TABLE_DEPTH fill steps,
//  one generator step per cycle through the single table write port
//  reset clears the controller, generator, last word and seed (to 1)
//  a stalled result holds the final draw step; input takes one item at a time
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_core #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  slrg_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output slrg_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [slrg_pkg::WORD_W-1:0] i_cfg_data
);
    import slrg_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    slrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_data.operation),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    slrg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_range     (i_in_data.range),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/slrg_ctrl.sv
// ----------------------------------------------------------------------------
// slrg_ctrl
// Sequencer for reseed fill and the draw read-modify-write
// ----------------------------------------------------------------------------
module slrg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [0:0]        i_operation,
    output logic              o_in_stall,
    input  slrg_pkg::t_status i_status,
    output slrg_pkg::t_cmd    o_cmd
);
    import slrg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_FILL      = 6'b000010,
        S_DRAW_IDX  = 6'b000100,
        S_DRAW_FIX  = 6'b001000,
        S_DRAW_SWAP = 6'b010000,
        S_DRAW_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_RESEED) begin
                        o_cmd.load_seed = 1'b1;
                        n_state         = S_FILL;
                    end else begin
                        o_cmd.capture_range = 1'b1;
                        n_state             = S_DRAW_IDX;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW_IDX: begin
                o_cmd.draw_index = 1'b1;
                n_state          = S_DRAW_FIX;
            end
            S_DRAW_FIX: begin
                o_cmd.draw_fix = 1'b1;
                n_state        = S_DRAW_SWAP;
            end
            S_DRAW_SWAP: begin
                o_cmd.draw_swap = 1'b1;
                n_state         = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                // hold until the output register is free
                if (!i_status.out_blocked) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/slrg_datapath.sv
// ----------------------------------------------------------------------------
// slrg_datapath
// Generator register, shuffle table memory, index and scaling arithmetic
// ----------------------------------------------------------------------------
module slrg_datapath #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [slrg_pkg::WORD_W-1:0]   i_cfg_data,
    input  logic [slrg_pkg::WORD_W-1:0]   i_range,
    input  slrg_pkg::t_cmd                i_cmd,
    output slrg_pkg::t_status             o_status,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output slrg_pkg::t_out_item           o_out_data
);
    import slrg_pkg::*;

    localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
    localparam int unsigned Q_W      = IDX_W + 1;
    localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + WARMUP_STEPS);
    localparam logic [63:0] PICK_DIV = 64'd1 + (64'h7FFF_FFFE / TABLE_DEPTH);
    localparam int unsigned RECIP_SH = 38;
    localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / PICK_DIV;
    localparam int unsigned QP_W     = RECIP_SH + Q_W;
    localparam int unsigned BND_W    = 40;

    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_gen;
    logic [WORD_W-1:0] r_last;
    logic [WORD_W-1:0] r_range;
    logic [CNT_W-1:0]  r_cnt;
    logic [Q_W-1:0]    r_q;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_capped;
    logic [WORD_W-1:0] r_word;
    logic [62:0]       r_prod;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [WORD_W-1:0] gen_next;
    logic [QP_W-1:0]   q_prod;
    logic [BND_W-1:0]  bound;
    logic [Q_W-1:0]    q_fix;
    logic [IDX_W-1:0]  idx_c;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              capped_c;
    logic [31:0]       mul_a;
    logic [WORD_W-1:0] red_hi;
    logic [31:0]       red_sum;
    logic [31:0]       quot;
    t_out_item         out_c;

    assign gen_next = lehmer_step(r_gen);

    assign o_status.fill_done   = (r_cnt == '0);
    assign o_status.out_blocked = r_out_valid && i_out_stall;

    // reciprocal estimate, low by at most one
    assign q_prod = QP_W'(r_last) * QP_W'(RECIP);

    always_comb begin
        bound = BND_W'(r_q + Q_W'(1)) * BND_W'(PICK_DIV);
        q_fix = r_q;
        if (BND_W'(r_last) >= bound) begin
            q_fix = r_q + Q_W'(1);
        end
        if (q_fix >= Q_W'(TABLE_DEPTH)) begin
            q_fix = Q_W'(TABLE_DEPTH - 1);
        end
        idx_c = q_fix[IDX_W-1:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_gen;
        if (i_cmd.fill_step && (r_cnt < CNT_W'(TABLE_DEPTH))) begin
            mem_we    = 1'b1;
            mem_waddr = r_cnt[IDX_W-1:0];
            mem_wdata = gen_next;
        end else if (i_cmd.draw_swap) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.draw_fix) begin
            r_rd_data <= mem[idx_c];
        end
    end

    assign capped_c = (r_rd_data > CAP_WORD);
    assign mul_a    = capped_c ? RNMX_Q32 : {1'b0, r_rd_data};

    // divide by the mersenne modulus: q = hi + carries of (hi + lo)
    always_comb begin
        red_hi  = r_prod[61:31];
        red_sum = {1'b0, red_hi} + {1'b0, r_prod[30:0]};
        quot    = {1'b0, red_hi};
        if (red_sum >= {1'b0, IM}) begin
            quot = quot + 32'd1;
        end
        if (red_sum >= {IM, 1'b0}) begin
            quot = quot + 32'd1;
        end
        if (r_capped) begin
            out_c.scaled_value  = r_prod[62:32];
            out_c.fraction_word = CAP_WORD;
        end else begin
            out_c.scaled_value  = quot[WORD_W-1:0];
            out_c.fraction_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_range) begin
            r_range <= i_range;
        end
        if (i_cmd.draw_index) begin
            r_q <= q_prod[RECIP_SH +: Q_W];
        end
        if (i_cmd.draw_fix) begin
            r_idx <= idx_c;
        end
        if (i_cmd.draw_swap) begin
            r_capped <= capped_c;
            r_word   <= r_rd_data;
            r_prod   <= 63'(mul_a) * 63'(r_range);
        end
        if (i_cmd.load_seed) begin
            r_cnt <= CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);
        end else if (i_cmd.fill_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out <= out_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= WORD_W'(1);
            r_gen       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.load_seed) begin
                r_gen <= r_seed;
            end else if (i_cmd.fill_step || i_cmd.draw_index) begin
                r_gen <= gen_next;
            end
            // entry 0 is written by the final fill step
            if (i_cmd.fill_step && (r_cnt == '0)) begin
                r_last <= gen_next;
            end else if (i_cmd.draw_swap) begin
                r_last <= r_rd_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/slrg_checker.sv
// ----------------------------------------------------------------------------
// slrg_checker
// Port-level checks for the shuffled lehmer generator, bound to the top level
// ----------------------------------------------------------------------------
module slrg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input slrg_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input slrg_pkg::t_out_item o_out_data
);
    import slrg_pkg::*;

    logic in_xfer;

    assign in_xfer = i_in_valid && !o_in_stall;

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");

    // one item at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while busy");

    // a reseed produces no result
    a_reseed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_data.operation == OP_RESEED) && !o_out_valid |=> !o_out_valid)
        else $error("reseed produced a result");

    // capped word bounds both result fields
    a_word_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fraction_word <= CAP_WORD)
                     && (o_out_data.scaled_value <= o_out_data.fraction_word))
        else $error("result above cap");

endmodule

bind shuffled_lehmer_random_generator_core slrg_checker u_slrg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/shuffled_lehmer_random_generator_core_test.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core_test
// Self-checking bench for the shuffled lehmer generator core: a shadow model
// of the generator, shuffle table and last word predicts each draw, and
// every result transfer is compared field by field with the oldest
// prediction. The input idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import slrg_pkg::t_in_item;
    import slrg_pkg::t_out_item;
    import slrg_pkg::OP_DRAW;
    import slrg_pkg::OP_RESEED;
    import slrg_pkg::WORD_W;

    localparam int          SLOTS        = 32;
    localparam int          WARMUP       = 8;
    localparam logic [63:0] MODULUS      = 64'd2147483647;
    localparam logic [63:0] LEHMER_MULT  = 64'd16807;
    localparam logic [63:0] LEHMER_INV   = 64'd1407677000;
    localparam logic [63:0] CAP_FRAC     = 64'd4294966781;
    localparam logic [63:0] CAP_PRODUCT  = CAP_FRAC * MODULUS;
    localparam logic [30:0] CAP_LIMIT    = CAP_PRODUCT[62:32];
    localparam logic [30:0] PICK_SPAN    = 31'((MODULUS - 64'd1) / SLOTS + 64'd1);
    localparam logic [30:0] WORD_MAX     = 31'h7FFF_FFFF;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          IDLE_LIMIT   = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [WORD_W-1:0]   i_cfg_data;

    // shadow copy of the block state
    logic [30:0] shadow_seed;
    logic [30:0] shadow_gen;
    logic [30:0] shadow_last;
    logic [30:0] shadow_words [SLOTS];

    t_out_item   pending_draws [$];
    t_out_item   expected_result;
    int          error_count = 0;
    int          idle_cycles = 0;
    logic        quiet = 1'b0;

    shuffled_lehmer_random_generator_core #(
        .TABLE_DEPTH (SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [30:0] next_lehmer(input logic [30:0] x);
        logic [63:0] prod;
        prod = {33'd0, x} * LEHMER_MULT;
        prod = prod % MODULUS;
        return prod[30:0];
    endfunction

    function automatic logic [30:0] pick_range();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 2))
                0: return 31'd0;
                1: return 31'd1;
                default: return WORD_MAX;
            endcase
        end else if (roll < 3) begin
            return 31'($urandom_range(1, 100));
        end
        return 31'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic reset_shadow();
        shadow_seed = 31'd1;
        shadow_gen  = '0;
        shadow_last = '0;
        foreach (shadow_words[i]) begin
            shadow_words[i] = '0;
        end
    endtask

    // advance the shadow state by one accepted item
    task automatic predict_outcome(input t_in_item item);
        logic [63:0] word;
        logic [63:0] rng;
        logic [63:0] prod;
        int          idx;
        int          n;
        t_out_item   res;
        if (item.operation == OP_RESEED) begin
            shadow_gen = shadow_seed;
            for (n = WARMUP + SLOTS - 1; n >= 0; n--) begin
                shadow_gen = next_lehmer(shadow_gen);
                if (n < SLOTS) begin
                    shadow_words[n] = shadow_gen;
                end
            end
            shadow_last = shadow_words[0];
        end else begin
            shadow_gen = next_lehmer(shadow_gen);
            idx = int'(shadow_last / PICK_SPAN);
            if (idx >= SLOTS) begin
                idx = SLOTS - 1;
            end
            word = {33'd0, shadow_words[idx]};
            shadow_last = word[30:0];
            shadow_words[idx] = shadow_gen;
            rng = {33'd0, item.range};
            if ((word << 32) > CAP_PRODUCT) begin
                prod = CAP_FRAC * rng;
                res.scaled_value  = prod[62:32];
                res.fraction_word = CAP_LIMIT;
            end else begin
                prod = (word * rng) / MODULUS;
                res.scaled_value  = prod[30:0];
                res.fraction_word = word[30:0];
            end
            pending_draws.push_back(res);
        end
    endtask

    task automatic send_item(input logic [0:0] op, input logic [30:0] rng);
        t_in_item item;
        int       gap;
        int       roll;
        item.operation = op;
        item.range     = rng;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            gap = 0;
        end else if (roll < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_outcome(item);
    endtask

    // wait for every result, then for a reseed still running to finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [30:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_seed = value;
    endtask

    // reset seed of one, range extremes, single-bit and alternating-bit patterns
    task automatic test_reset_seed_draws();
        send_item(OP_RESEED, 31'($urandom));
        send_item(OP_DRAW, 31'd1);
        send_item(OP_DRAW, 31'd0);
        send_item(OP_DRAW, WORD_MAX);
        send_item(OP_DRAW, 31'd2);
        send_item(OP_DRAW, 31'h2AAA_AAAA);
        send_item(OP_DRAW, 31'h5555_5555);
        send_item(OP_DRAW, 31'h4000_0000);
    endtask

    task automatic test_back_to_back_reseed();
        send_item(OP_RESEED, 31'h7FFF_FFFF);
        send_item(OP_RESEED, 31'd0);
        send_item(OP_DRAW, pick_range());
    endtask

    // zero and the modulus both collapse the generator to zero
    task automatic test_degenerate_seeds();
        write_seed(31'd0);
        send_item(OP_RESEED, pick_range());
        send_item(OP_DRAW, WORD_MAX);
        send_item(OP_DRAW, pick_range());
        write_seed(WORD_MAX);
        send_item(OP_RESEED, pick_range());
        send_item(OP_DRAW, WORD_MAX);
    endtask

    task automatic test_seed_extremes();
        write_seed(31'h7FFF_FFFE);
        send_item(OP_RESEED, pick_range());
        send_item(OP_DRAW, WORD_MAX);
        write_seed(31'd1);
        send_item(OP_RESEED, pick_range());
        send_item(OP_DRAW, pick_range());
        send_item(OP_DRAW, WORD_MAX);
    endtask

    // steer the generator so that the first draw stores a word at the cap
    // boundary; it comes out once its slot is picked
    task automatic test_capped_words();
        logic [30:0] targets [3];
        logic [63:0] x;
        targets[0] = CAP_LIMIT;
        targets[1] = CAP_LIMIT + 31'd1;
        targets[2] = 31'h7FFF_FFFE;
        foreach (targets[t]) begin
            x = {33'd0, targets[t]};
            repeat (WARMUP + SLOTS + 1) x = (x * LEHMER_INV) % MODULUS;
            write_seed(x[30:0]);
            send_item(OP_RESEED, pick_range());
            repeat (60) send_item(OP_DRAW, pick_range());
        end
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            write_seed(31'($urandom_range(1, 32'h7FFF_FFFE)));
            quiet = (phase == 2);
            send_item(OP_RESEED, pick_range());
            repeat (35) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_item(OP_RESEED, 31'($urandom));
                end else begin
                    send_item(OP_DRAW, pick_range());
                end
            end
            quiet = 1'b0;
        end
    endtask

    // result side stalls: mostly short, now and then long
    initial begin : out_stall_driver
        int hold;
        int roll;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                i_out_stall <= 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                    hold = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(15, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing pending: %h",
                                          o_out_data));
            end else begin
                expected_result = pending_draws.pop_front();
                if (o_out_data.scaled_value !== expected_result.scaled_value) begin
                    report_mismatch($sformatf("scaled_value %0d, expected %0d",
                                              o_out_data.scaled_value,
                                              expected_result.scaled_value));
                end
                if (o_out_data.fraction_word !== expected_result.fraction_word) begin
                    report_mismatch($sformatf("fraction_word %0d, expected %0d",
                                              o_out_data.fraction_word,
                                              expected_result.fraction_word));
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : sequencer
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_seed_draws();
        test_back_to_back_reseed();
        test_degenerate_seeds();
        test_seed_extremes();
        test_capped_words();
        test_random_stream();
        drain();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
